// ===== rtl/cau_pkg.sv =====
// shared types and default sizes for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

endpackage

// ===== rtl/cau_front.sv =====
// front stage: registers an incoming word and flags a zero divisor
// depends on cau_pkg
module cau_front import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  output logic                        f_valid,
  input  logic                        f_ready,
  output logic [4*WORD_BITS+2:0]      f_data
);

  logic                        valid_r;
  logic [1:0]                  kind_r;
  logic                        dz_r;
  logic [WORD_BITS-1:0]        a_re_r, a_im_r, b_re_r, b_im_r;
  logic                        take;
  logic                        dz_nxt;

  assign in_ready = !valid_r || f_ready;
  assign take     = in_valid && in_ready;
  assign dz_nxt   = (kind_t'(in_kind) == KIND_DIV) && (in_b_re == '0) && (in_b_im == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (f_ready) begin
      valid_r <= 1'b0;
    end
    if (take) begin
      kind_r <= in_kind;
      dz_r   <= dz_nxt;
      a_re_r <= in_a_re;
      a_im_r <= in_a_im;
      b_re_r <= in_b_re;
      b_im_r <= in_b_im;
    end
  end

  assign f_valid = valid_r;
  assign f_data  = {kind_r, dz_r, a_re_r, a_im_r, b_re_r, b_im_r};

endmodule

// ===== rtl/cau_queue.sv =====
// short word queue between the front and back stages
// depends on cau_pkg for the default depth
module cau_queue import cau_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push, pop;

  assign wr_ready = (count_r != CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/cau_back.sv =====
// back stage: products, combine, saturate, and a bit-serial divider
// depends on cau_pkg
module cau_back import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  logic [4*WORD_BITS+2:0]      q_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic                        out_overflow,
  output logic                        out_div_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 2;
  localparam int MW = 2 * W + 1;
  localparam int NB = MW + F;
  localparam int RB = MW + 1;
  localparam int CW = $clog2(NB + 1);
  localparam logic signed [XW-1:0] BIAS = (XW'(1) << F) - XW'(1);
  localparam logic signed [XW-1:0] MAXV = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] MINV = -(XW'(1) << (W - 1));

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} div_state_t;

  // unpack head of queue
  logic [1:0]          h_kind_w;
  kind_t               h_kind;
  logic                h_dz;
  logic signed [W-1:0] h_ar, h_ai, h_br, h_bi;
  assign {h_kind_w, h_dz, h_ar, h_ai, h_br, h_bi} = q_data;
  assign h_kind = kind_t'(h_kind_w);

  // product stage
  logic                 s1_v_r;
  kind_t                s1_kind_r;
  logic                 s1_dz_r;
  logic signed [W:0]    s1_sre_r, s1_sim_r;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ir_r, p_ri_r, sq_r_r, sq_i_r;

  div_state_t           div_state_r;
  logic [CW-1:0]        cnt_r;
  logic [NB-1:0]        num_re_r, num_im_r;
  logic [RB-1:0]        rem_re_r, rem_im_r;
  logic [MW-1:0]        den_r;
  logic                 neg_re_r, neg_im_r;

  logic                 out_v_r;
  logic signed [W-1:0]  res_re_r, res_im_r;
  logic                 ov_r, dz_r;

  logic out_free, div_idle, s1_isdiv, s1_go_out, s1_go_div, s1_free, issue;

  assign out_free  = !out_v_r || out_ready;
  assign div_idle  = (div_state_r == D_IDLE);
  assign s1_isdiv  = (s1_kind_r == KIND_DIV) && !s1_dz_r;
  assign s1_go_out = s1_v_r && !s1_isdiv && div_idle && out_free;
  assign s1_go_div = s1_v_r && s1_isdiv && div_idle;
  assign s1_free   = !s1_v_r || s1_go_out || s1_go_div;
  assign q_ready   = s1_free;
  assign issue     = q_valid && s1_free;

  function automatic logic signed [XW-1:0] ext(input logic signed [PW-1:0] p);
    return {{(XW - PW){p[PW-1]}}, p};
  endfunction

  function automatic logic signed [XW-1:0] trunc_shift(input logic signed [XW-1:0] s);
    logic signed [XW-1:0] t;
    t = s[XW-1] ? s + BIAS : s;
    return t >>> F;
  endfunction

  function automatic logic [W:0] sat_wide(input logic signed [XW-1:0] v);
    if (v > MAXV) begin
      return {1'b1, MAXV[W-1:0]};
    end else if (v < MINV) begin
      return {1'b1, MINV[W-1:0]};
    end
    return {1'b0, v[W-1:0]};
  endfunction

  // magnitude to signed word, flag in top bit
  function automatic logic [W:0] sat_mag(input logic [NB-1:0] m, input logic neg);
    logic [NB-1:0] lim;
    logic [W-1:0]  mw;
    lim = (NB'(1) << (W - 1)) - (neg ? NB'(0) : NB'(1));
    if (m > lim) begin
      mw = lim[W-1:0];
      return {1'b1, neg ? -mw : mw};
    end
    mw = m[W-1:0];
    return {1'b0, neg ? -mw : mw};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (issue) begin
      s1_v_r <= 1'b1;
    end else if (s1_free) begin
      s1_v_r <= 1'b0;
    end
    if (issue) begin
      s1_kind_r <= h_kind;
      s1_dz_r   <= h_dz;
      s1_sre_r  <= (h_kind == KIND_ADD) ? {h_ar[W-1], h_ar} + {h_br[W-1], h_br}
                                        : {h_ar[W-1], h_ar} - {h_br[W-1], h_br};
      s1_sim_r  <= (h_kind == KIND_ADD) ? {h_ai[W-1], h_ai} + {h_bi[W-1], h_bi}
                                        : {h_ai[W-1], h_ai} - {h_bi[W-1], h_bi};
      p_rr_r    <= h_ar * h_br;
      p_ii_r    <= h_ai * h_bi;
      p_ir_r    <= h_ai * h_br;
      p_ri_r    <= h_ar * h_bi;
      sq_r_r    <= h_br * h_br;
      sq_i_r    <= h_bi * h_bi;
    end
  end

  // combine for the non-divide path
  logic signed [XW-1:0] wide_re, wide_im;
  logic [W:0]           sat_re, sat_im;

  always_comb begin
    unique case (s1_kind_r)
      KIND_ADD, KIND_SUB: begin
        wide_re = {{(XW - W - 1){s1_sre_r[W]}}, s1_sre_r};
        wide_im = {{(XW - W - 1){s1_sim_r[W]}}, s1_sim_r};
      end
      KIND_MUL: begin
        wide_re = trunc_shift(ext(p_rr_r) - ext(p_ii_r));
        wide_im = trunc_shift(ext(p_ir_r) + ext(p_ri_r));
      end
      default: begin
        wide_re = '0;
        wide_im = '0;
      end
    endcase
    sat_re = sat_wide(wide_re);
    sat_im = sat_wide(wide_im);
  end

  // divider load values
  logic signed [XW-1:0] n_re, n_im, den_w;
  logic [XW-1:0]        mag_re, mag_im;
  assign n_re   = ext(p_rr_r) + ext(p_ii_r);
  assign n_im   = ext(p_ir_r) - ext(p_ri_r);
  assign den_w  = ext(sq_r_r) + ext(sq_i_r);
  assign mag_re = n_re[XW-1] ? -n_re : n_re;
  assign mag_im = n_im[XW-1] ? -n_im : n_im;

  // one restoring step for each part
  logic [RB-1:0] tr_re, tr_im;
  logic          qb_re, qb_im;
  assign tr_re = {rem_re_r[RB-2:0], num_re_r[NB-1]};
  assign tr_im = {rem_im_r[RB-2:0], num_im_r[NB-1]};
  assign qb_re = (tr_re >= RB'(den_r));
  assign qb_im = (tr_im >= RB'(den_r));

  logic [W:0] q_sat_re, q_sat_im;
  assign q_sat_re = sat_mag(num_re_r, neg_re_r);
  assign q_sat_im = sat_mag(num_im_r, neg_im_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= D_IDLE;
      out_v_r     <= 1'b0;
    end else begin
      unique case (div_state_r)
        D_IDLE: begin
          if (s1_go_div) begin
            div_state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (cnt_r == CW'(1)) begin
            div_state_r <= D_DONE;
          end
        end
        D_DONE: begin
          if (out_free) begin
            div_state_r <= D_IDLE;
          end
        end
        default: div_state_r <= D_IDLE;
      endcase
      if ((div_state_r == D_DONE && out_free) || s1_go_out) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end

    if (s1_go_div) begin
      cnt_r    <= CW'(NB);
      num_re_r <= NB'(mag_re[MW-1:0]) << F;
      num_im_r <= NB'(mag_im[MW-1:0]) << F;
      rem_re_r <= '0;
      rem_im_r <= '0;
      den_r    <= den_w[MW-1:0];
      neg_re_r <= n_re[XW-1];
      neg_im_r <= n_im[XW-1];
    end else if (div_state_r == D_RUN) begin
      cnt_r    <= cnt_r - CW'(1);
      rem_re_r <= qb_re ? tr_re - RB'(den_r) : tr_re;
      rem_im_r <= qb_im ? tr_im - RB'(den_r) : tr_im;
      num_re_r <= {num_re_r[NB-2:0], qb_re};
      num_im_r <= {num_im_r[NB-2:0], qb_im};
    end

    if (div_state_r == D_DONE && out_free) begin
      res_re_r <= q_sat_re[W-1:0];
      res_im_r <= q_sat_im[W-1:0];
      ov_r     <= q_sat_re[W] || q_sat_im[W];
      dz_r     <= 1'b0;
    end else if (s1_go_out) begin
      res_re_r <= sat_re[W-1:0];
      res_im_r <= sat_im[W-1:0];
      ov_r     <= sat_re[W] || sat_im[W];
      dz_r     <= s1_dz_r;
    end
  end

  assign out_valid       = out_v_r;
  assign out_res_re      = res_re_r;
  assign out_res_im      = res_im_r;
  assign out_overflow    = ov_r;
  assign out_div_by_zero = dz_r;

endmodule

// ===== rtl/complex_arith_unit.sv =====
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Add, subtract and multiply words stream at one per cycle while the output is
// not stalled and no divide is in progress; the result passes through the front
// register, the queue, the product stage and the output register. A divide runs
// 2*WORD_BITS+FRAC_BITS+1 quotient steps (81 at the default sizes), one bit of
// each part per cycle, after a load from the product stage and before the
// result is written to the output register; words behind it wait in the
// queue meanwhile and then stall the input once the queue is full.
// Results come out in the order taken; a zero divisor gives a zero result with
// the divide-by-zero flag and does not use the divider.
// top level; depends on cau_pkg, cau_front, cau_queue, cau_back
module complex_arith_unit import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic signed [WORD_BITS-1:0] in_a_re,
  input  logic signed [WORD_BITS-1:0] in_a_im,
  input  logic signed [WORD_BITS-1:0] in_b_re,
  input  logic signed [WORD_BITS-1:0] in_b_im,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [WORD_BITS-1:0] out_res_re,
  output logic signed [WORD_BITS-1:0] out_res_im,
  output logic                        out_overflow,
  output logic                        out_div_by_zero
);

  localparam int EW = 4 * WORD_BITS + 3;

  logic          f_valid, f_ready, q_valid, q_ready;
  logic [EW-1:0] f_data, q_data;

  cau_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_kind, .in_a_re, .in_a_im, .in_b_re, .in_b_im,
    .f_valid, .f_ready, .f_data
  );

  cau_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH_DEF)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  cau_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_res_re, .out_res_im, .out_overflow, .out_div_by_zero
  );

endmodule

// ===== rtl/cau_checker.sv =====
// port-level checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arith_unit
module cau_checker import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic signed [WORD_BITS-1:0] out_res_re,
  input logic signed [WORD_BITS-1:0] out_res_im,
  input logic                        out_overflow,
  input logic                        out_div_by_zero
);

  localparam logic signed [WORD_BITS-1:0] MAXW = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [WORD_BITS-1:0] MINW = {1'b1, {(WORD_BITS - 1){1'b0}}};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_re) && $stable(out_res_im)
      && $stable(out_overflow) && $stable(out_div_by_zero))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_res_re == '0 && out_res_im == '0 && !out_overflow)
    else $error("zero divisor result not clean");

  a_ov: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_res_re == MAXW || out_res_re == MINW
      || out_res_im == MAXW || out_res_im == MINW)
    else $error("overflow without a saturated part");

endmodule

bind complex_arith_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
  .out_res_re(out_res_re), .out_res_im(out_res_im), .out_overflow(out_overflow),
  .out_div_by_zero(out_div_by_zero)
);

// ===== tb/complex_arith_unit_checker.sv =====
// result checker for the complex arithmetic unit: watches both channels,
// predicts each result from the accepted operands and compares in order
// depends on cau_pkg
module complex_arith_unit_checker import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_res_re,
  input  logic signed [31:0] out_res_im,
  input  logic               out_overflow,
  input  logic               out_div_by_zero,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               ovf;
    logic               dbz;
  } cplx_res_t;

  cplx_res_t expected_q[$];

  // clamp a wide exact value into 32 bits
  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // signed division truncating toward zero on magnitudes
  function automatic logic signed [127:0] quot_trunc(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
    logic [127:0] mag;
    mag = ((n < 0) ? -n : n) / d;
    return (n < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cplx_res_t complex_result(input kind_t k,
      input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    logic signed [127:0] xr, xi, wr, wi, wbr, wbi, den;
    wr = ar; wi = ai; wbr = br; wbi = bi;
    r = '0;
    case (k)
      KIND_ADD: begin xr = wr + wbr; xi = wi + wbi; end
      KIND_SUB: begin xr = wr - wbr; xi = wi - wbi; end
      KIND_MUL: begin
        xr = wr * wbr - wi * wbi;
        xi = wi * wbr + wr * wbi;
        xr = quot_trunc(xr, 128'sd65536);
        xi = quot_trunc(xi, 128'sd65536);
      end
      default: begin
        den = wbr * wbr + wbi * wbi;
        if (den == 0) begin
          xr = 0; xi = 0; r.dbz = 1'b1;
        end else begin
          xr = quot_trunc((wr * wbr + wi * wbi) * 65536, den);
          xi = quot_trunc((wi * wbr - wr * wbi) * 65536, den);
        end
      end
    endcase
    r.re = clamp32(xr, r.ovf);
    r.im = clamp32(xi, r.ovf);
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    cplx_res_t e;
    if (!rst_n) begin
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(complex_result(kind_t'(in_kind), in_a_re, in_a_im,
                                            in_b_re, in_b_im));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word re=%h im=%h", $time, out_res_re, out_res_im);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e != {out_res_re, out_res_im, out_overflow, out_div_by_zero}) begin
            $display("%0t: mismatch expected re=%h im=%h ov=%b dz=%b actual re=%h im=%h ov=%b dz=%b",
                     $time, e.re, e.im, e.ovf, e.dbz,
                     out_res_re, out_res_im, out_overflow, out_div_by_zero);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/complex_arith_unit_test.sv =====
// top of the complex arithmetic unit testbench: clock, reset, stimulus,
// receiver stalls and verdict; depends on cau_pkg, the unit and its checker
module complex_arith_unit_test;
  import cau_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_kind;
  logic signed [31:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic signed [31:0] out_res_re, out_res_im;
  logic out_overflow, out_div_by_zero;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct;
  int idle_cycles;
  bit hold_off;

  complex_arith_unit u_dut (.*);

  complex_arith_unit_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("[complex_arith_unit] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(2) << 16;
      4: return $signed($urandom_range(65535)) - 32768;
      5: return $signed($urandom_range(32'h1ffffff)) - 32'sh1000000;
      default: return $urandom;
    endcase
  endfunction

  // valid stays up between back-to-back words and drops only while idling
  task automatic send_word(input kind_t k, input logic [31:0] ar, ai, br, bi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_a_re <= ar; in_a_im <= ai; in_b_re <= br; in_b_im <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    logic [31:0] br, bi;
    kind_t k;
    repeat (n) begin
      k = kind_t'($urandom_range(3));
      br = pick_operand();
      bi = pick_operand();
      if (k == KIND_DIV && $urandom_range(15) == 0) begin br = 0; bi = 0; end
      send_word(k, pick_operand(), pick_operand(), br, bi);
    end
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_kind = 0;
    in_a_re = 0; in_a_im = 0; in_b_re = 0; in_b_im = 0;
    hold_off = 0; send_idle_pct = 8; recv_idle_pct = 65;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed words: extremes, each operation, zero divisor, saturation
    for (int k = 0; k < 4; k++) begin
      send_word(kind_t'(k), 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send_word(kind_t'(k), 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00030000);
    end
    send_word(KIND_DIV, 32'h00050000, 32'h00070000, 32'h0, 32'h0);
    send_word(KIND_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    send_word(KIND_DIV, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h1);
    send_word(KIND_DIV, 32'h80000000, 32'h0, 32'hffffffff, 32'h0);
    send_word(KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_word(KIND_MUL, 32'hffffffff, 32'h1, 32'h1, 32'hffffffff);
    send_word(KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
    send_word(KIND_ADD, 32'hffffffff, 32'h0, 32'h1, 32'h0);
    send_random(400);
    // long receiver hold-off while words keep coming
    hold_off <= 1'b1;
    fork
      begin repeat (300) @(posedge clk); hold_off <= 1'b0; end
      send_random(20);
    join
    send_idle_pct = 65; recv_idle_pct = 8;
    send_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(400);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("[complex_arith_unit] OK");
    else $display("[complex_arith_unit] ERROR");
    $finish;
  end

endmodule
